### hdl/rtli_pkg.sv
// Shared types and constants for the ranked top list insert block.
package rtli_pkg;

  localparam int LISTS       = 256;
  localparam int LIST_LEN    = 20;
  localparam int TAG_MAX_LEN = 25;

  localparam int ROW_ADDR_W = (LISTS > 1) ? $clog2(LISTS) : 1;
  localparam int POS_W      = $clog2(LIST_LEN);
  localparam int RANK_W     = 5;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_LOW      = 2'd1,
    ST_REJECT   = 2'd2
  } rtli_status_t;

  typedef struct packed {
    logic [11:0] list_index;
    logic [30:0] value;
    logic        completed;
    logic [63:0] tag;
    logic [7:0]  tag_length;
  } rtli_in_t;

  typedef struct packed {
    rtli_status_t       status;
    logic [RANK_W-1:0]  rank;
  } rtli_out_t;

  typedef struct packed {
    logic        done;
    logic [30:0] value;
    logic [63:0] tag;
  } rtli_entry_t;

  typedef rtli_entry_t [LIST_LEN-1:0] rtli_row_t;

  // Passed from each cell to the one below it.
  typedef struct packed {
    logic              hit;
    logic [RANK_W-1:0] rank;
  } rtli_link_t;

endpackage

### hdl/rtli_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rtli_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/rtli_cell.sv
// One list position: compares, takes the new entry or shifts from above.
module rtli_cell
  import rtli_pkg::*;
(
  input  logic [POS_W-1:0] pos,
  input  rtli_entry_t      new_entry,
  input  rtli_entry_t      own,
  input  rtli_entry_t      upper,
  input  rtli_link_t       link_in,
  output rtli_link_t       link_out,
  output rtli_entry_t      entry_out
);

  logic le;
  logic here;

  assign le   = (new_entry.value >= own.value);
  assign here = le && !link_in.hit;

  assign link_out.hit  = link_in.hit || le;
  assign link_out.rank = here ? RANK_W'(pos) : link_in.rank;

  always_comb begin
    priority if (here) begin
      entry_out = new_entry;
    end else if (link_in.hit) begin
      entry_out = upper;
    end else begin
      entry_out = own;
    end
  end

endmodule

### hdl/ranked_top_list_insert.sv
// Each item passes through the READ and MERGE states: the registered list-row read,
// then the compare-and-shift pass and write back through the cell row. A new item is taken
// only in IDLE, and MERGE waits while a result is held at the output by rsp_stall.
// A new item is taken while an earlier result still waits at the output.
// Reset clears one valid bit per list; an unwritten list reads as all zero.
module ranked_top_list_insert
  import rtli_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  rtli_in_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rtli_out_t rsp
);

  typedef enum logic [1:0] {
    IDLE,
    READ,
    MERGE
  } state_t;

  localparam logic [12:0] LISTS_C   = 13'(LISTS);
  localparam logic [7:0]  TAG_MAX_C = 8'(TAG_MAX_LEN);

  state_t                  state;
  rtli_in_t                item;
  logic                    bad;
  logic [LISTS-1:0]        row_valid;
  logic                    row_hit;
  logic [ROW_ADDR_W-1:0]   row_addr;
  rtli_row_t               rdata;
  rtli_row_t               cur_row;
  rtli_row_t               new_row;
  rtli_entry_t             new_entry;
  rtli_link_t              link [LIST_LEN+1];
  logic                    accept;
  logic                    advance;
  logic                    inserted;
  logic                    bad_next;

  assign req_stall = (state != IDLE);
  assign accept    = req_valid && !req_stall;
  assign bad_next  = ({1'b0, req.list_index} >= LISTS_C) || (req.tag_length == 8'd0) ||
                     (req.tag_length > TAG_MAX_C);

  assign row_addr  = ROW_ADDR_W'(item.list_index);
  assign cur_row   = row_hit ? rdata : '0;
  assign new_entry = '{done: item.completed, value: item.value, tag: item.tag};

  rtli_ram #(
    .WIDTH ($bits(rtli_row_t)),
    .DEPTH (LISTS)
  ) u_ram (
    .clk   (clk),
    .we    (advance && inserted),
    .waddr (row_addr),
    .wdata (new_row),
    .raddr (row_addr),
    .rdata (rdata)
  );

  assign link[0] = '{hit: 1'b0, rank: '0};

  for (genvar j = 0; j < LIST_LEN; j++) begin : g_cell
    rtli_cell u_cell (
      .pos       (POS_W'(j)),
      .new_entry (new_entry),
      .own       (cur_row[j]),
      .upper     (cur_row[(j == 0) ? 0 : j - 1]),
      .link_in   (link[j]),
      .link_out  (link[j+1]),
      .entry_out (new_row[j])
    );
  end

  assign inserted = link[LIST_LEN].hit && !bad;
  assign advance  = (state == MERGE) && !(rsp_valid && rsp_stall);

  // The valid bit follows the same address as the RAM read, so it lines up with rdata.
  always_ff @(posedge clk) begin
    row_hit <= row_valid[row_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      if (rsp_valid && !rsp_stall && !advance) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            item  <= req;
            bad   <= bad_next;
            state <= READ;
          end
        end
        READ: begin
          state <= MERGE;
        end
        MERGE: begin
          if (advance) begin
            rsp_valid <= 1'b1;
            if (bad) begin
              rsp.status <= ST_REJECT;
            end else if (link[LIST_LEN].hit) begin
              rsp.status <= ST_INSERTED;
            end else begin
              rsp.status <= ST_LOW;
            end
            rsp.rank <= inserted ? link[LIST_LEN].rank : '0;
            if (inserted) begin
              row_valid[row_addr] <= 1'b1;
            end
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

### tb/sv/ranked_top_list_insert_tb.sv
// Self-checking testbench for the ranked top list insert block.
module ranked_top_list_insert_tb;
  import rtli_pkg::*;

  typedef struct {
    rtli_in_t  item;
    bit        fixed;
    rtli_out_t result;
  } probe_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  rtli_in_t  req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  rtli_out_t rsp;

  // Shadow copy of every ranked list, entry p of list L at L*LIST_LEN + p.
  rtli_entry_t board [LISTS*LIST_LEN];
  rtli_out_t   expected_results [$];
  probe_t      probes [$];
  logic [30:0] value_pool [16];
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          mismatch_count = 0;
  int          idle_by_phase [4] = '{0, 62, 0, 23};
  int          stall_by_phase [4] = '{0, 0, 62, 23};

  ranked_top_list_insert i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #1600000;
    $display("** ranked_top_list_insert: FAILED **");
    $finish;
  end

  // Applies one insert to the shadow lists and returns the result it should give.
  function automatic rtli_out_t rank_insert(rtli_in_t it);
    rtli_out_t   r;
    int unsigned base;
    int          pos;
    r.status = ST_REJECT;
    r.rank   = '0;
    if (it.list_index >= LISTS || it.tag_length == 0 || it.tag_length > TAG_MAX_LEN) begin
      return r;
    end
    base = it.list_index * LIST_LEN;
    pos  = -1;
    for (int j = 0; j < LIST_LEN; j++) begin
      if (pos < 0 && it.value >= board[base + j].value) begin
        pos = j;
      end
    end
    if (pos < 0) begin
      r.status = ST_LOW;
      return r;
    end
    for (int j = LIST_LEN - 1; j > pos; j--) begin
      board[base + j] = board[base + j - 1];
    end
    board[base + pos].done  = it.completed;
    board[base + pos].value = it.value;
    board[base + pos].tag   = it.tag;
    r.status = ST_INSERTED;
    r.rank   = pos[RANK_W-1:0];
    return r;
  endfunction

  function automatic void add_probe(int idx, logic [30:0] val, bit done, logic [63:0] tag,
                                    int tlen, bit fixed, rtli_status_t st, int rk);
    probe_t p;
    p.item.list_index = idx[11:0];
    p.item.value      = val;
    p.item.completed  = done;
    p.item.tag        = tag;
    p.item.tag_length = tlen[7:0];
    p.fixed           = fixed;
    p.result.status   = st;
    p.result.rank     = rk[RANK_W-1:0];
    probes.push_back(p);
  endfunction

  // Most items are well formed and aimed at a few busy lists so that they fill up;
  // the rest carry arbitrary indexes and lengths.
  function automatic rtli_in_t random_insert();
    rtli_in_t it;
    it.value     = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 15)] : 31'($urandom);
    it.completed = 1'($urandom_range(0, 1));
    it.tag       = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 85) begin
      it.list_index = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, 5))
                                                  : 12'($urandom_range(0, LISTS - 1));
      it.tag_length = 8'($urandom_range(1, TAG_MAX_LEN));
    end else begin
      it.list_index = 12'($urandom);
      it.tag_length = 8'($urandom);
    end
    return it;
  endfunction

  task automatic send_insert(input rtli_in_t item, input bit fixed, input rtli_out_t fixed_result);
    rtli_out_t predicted;
    while ($urandom_range(0, 99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = rank_insert(item);
    expected_results.push_back(fixed ? fixed_result : predicted);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rsp_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    rtli_out_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result transfer: status %0d rank %0d", rsp.status, rsp.rank);
        end
      end else begin
        want = expected_results.pop_front();
        if (rsp.status !== want.status || rsp.rank !== want.rank) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("result mismatch: expected status %0d rank %0d, got status %0d rank %0d",
                     want.status, want.rank, rsp.status, rsp.rank);
          end
        end
      end
    end
  end

  initial begin
    for (int a = 0; a < LISTS * LIST_LEN; a++) begin
      board[a] = '0;
    end
    value_pool[0] = '0;
    value_pool[1] = '1;
    value_pool[2] = 31'd1;
    for (int i = 3; i < 16; i++) begin
      value_pool[i] = 31'($urandom);
    end

    // Rejected inputs, then a fresh list, then a list filled to the end with the top value.
    add_probe(LISTS, 31'd5, 1'b0, 64'h1, 1, 1'b1, ST_REJECT, 0);
    add_probe(0, 31'd5, 1'b0, 64'h2, 0, 1'b1, ST_REJECT, 0);
    add_probe(0, 31'd5, 1'b1, 64'h3, TAG_MAX_LEN + 1, 1'b1, ST_REJECT, 0);
    add_probe(4095, '1, 1'b1, '1, 255, 1'b1, ST_REJECT, 0);
    add_probe(0, '0, 1'b0, '0, 1, 1'b1, ST_INSERTED, 0);
    add_probe(0, 31'd100, 1'b1, 64'h100, TAG_MAX_LEN, 1'b0, ST_INSERTED, 0);
    add_probe(0, 31'd50, 1'b0, 64'h50, 7, 1'b0, ST_INSERTED, 0);
    add_probe(0, '0, 1'b1, 64'h5a5a, 3, 1'b0, ST_INSERTED, 0);
    for (int i = 0; i < LIST_LEN; i++) begin
      add_probe(LISTS - 1, '1, i[0], ~64'(i), i[0] ? TAG_MAX_LEN : 1, 1'b1, ST_INSERTED, 0);
    end
    add_probe(LISTS - 1, 31'h7FFF_FFFE, 1'b0, 64'hdead, 2, 1'b1, ST_LOW, 0);
    add_probe(LISTS - 1, '1, 1'b0, 64'hbeef, 2, 1'b1, ST_INSERTED, 0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (probes[i]) begin
      send_insert(probes[i].item, probes[i].fixed, probes[i].result);
    end
    // Hold off until the last directed transfer has come back.
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      idle_pct  = idle_by_phase[phase];
      stall_pct = stall_by_phase[phase];
      for (int n = 0; n < 230; n++) begin
        send_insert(random_insert(), 1'b0, '0);
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("** ranked_top_list_insert: PASSED **");
    end else begin
      $display("** ranked_top_list_insert: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
hdl/rtli_pkg.sv
hdl/rtli_ram.sv
hdl/rtli_cell.sv
hdl/ranked_top_list_insert.sv
tb/sv/ranked_top_list_insert_tb.sv
